@@ sv/vector4_normalize_defines.svh @@
// assertion macros shared by the vector normaliser rtl
`ifndef VECTOR4_NORMALIZE_DEFINES_SVH
`define VECTOR4_NORMALIZE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define VN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vn assertion failed");

// next-cycle implication
`define VN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vn assertion failed");

`endif

@@ sv/vn_pkg.sv @@
// shared widths and constants of the vector normaliser
package vn_pkg;
	localparam int COMP_W      = 16;
	localparam int MAG_W       = 17;
	localparam int SUM_W       = 33;
	localparam int RAD_W       = 34;
	localparam int ROOT_STAGES = 17;
	localparam int REM_W       = 19;
	localparam int QUO_W       = 15;
	localparam int DIV_R_W     = 18;
	localparam int LANES       = 4;
	localparam int LANE_LAT    = QUO_W + 2;
	localparam logic [COMP_W-1:0] ONE_Q14     = 16'd16384;
	localparam logic [MAG_W-1:0]  MIN_LEN_RST = 17'd4;

	typedef logic [LANES-1:0][COMP_W-1:0] comp4_t;
endpackage

@@ sv/vn_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module vn_isqrt import vn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [RAD_W-1:0] radicand,
	input  comp4_t           vec_in,
	output logic             out_valid,
	output logic [MAG_W-1:0] root,
	output comp4_t           vec_out
);
	logic             v_s   [0:ROOT_STAGES];
	logic [REM_W-1:0] rem_s [0:ROOT_STAGES];
	logic [MAG_W-1:0] root_s[0:ROOT_STAGES];
	logic [RAD_W-1:0] rad_s [0:ROOT_STAGES];
	comp4_t           vec_s [0:ROOT_STAGES];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;
	assign vec_s[0]  = vec_in;

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             ge;
		always_comb begin
			cur   = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = (cur >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
			root_s[k+1] <= {root_s[k][MAG_W-2:0], ge};
			rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
			vec_s[k+1]  <= vec_s[k];
		end
	end

	assign out_valid = v_s[ROOT_STAGES];
	assign root      = root_s[ROOT_STAGES];
	assign vec_out   = vec_s[ROOT_STAGES];
endmodule

@@ sv/vn_div_lane.sv @@
// one divider lane: rounded q1.14 quotient of a component over the length
module vn_div_lane import vn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [COMP_W-1:0] comp,
	input  logic [MAG_W-1:0]         len,
	output logic                     out_valid,
	output logic [COMP_W-1:0]        unit
);
	logic                 v_s  [0:QUO_W];
	logic [DIV_R_W-1:0]   r_s  [0:QUO_W];
	logic [QUO_W-1:0]     n_s  [0:QUO_W];
	logic [QUO_W-1:0]     q_s  [0:QUO_W];
	logic [DIV_R_W-1:0]   d_s  [0:QUO_W];
	logic                 neg_s[0:QUO_W];

	logic [COMP_W-1:0]    mag_a;
	logic [30:0]          numer;
	logic [QUO_W:0]       q_sat;
	logic                 out_v_q;
	logic [COMP_W-1:0]    unit_q;

	// magnitude, numerator a*2^15+len and divisor 2*len
	always_comb begin
		mag_a = comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
		numer = {mag_a, 15'd0} + {14'd0, len};
		if (mag_a[15]) begin
			numer = {1'b1, 30'd0} + {14'd0, len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_s[0]   <= {2'b00, numer[30:15]};
		n_s[0]   <= numer[14:0];
		q_s[0]   <= '0;
		d_s[0]   <= {len, 1'b0};
		neg_s[0] <= comp[COMP_W-1];
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DIV_R_W:0] t;
		logic             ge;
		always_comb begin
			t  = {r_s[k], n_s[k][QUO_W-1]};
			ge = (t >= {1'b0, d_s[k]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			r_s[k+1]   <= ge ? DIV_R_W'(t - {1'b0, d_s[k]}) : DIV_R_W'(t);
			n_s[k+1]   <= {n_s[k][QUO_W-2:0], 1'b0};
			q_s[k+1]   <= {q_s[k][QUO_W-2:0], ge};
			d_s[k+1]   <= d_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	// clamp to one, then apply the sign
	always_comb begin
		q_sat = ({1'b0, q_s[QUO_W]} > ONE_Q14) ? ONE_Q14 : {1'b0, q_s[QUO_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= v_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		unit_q <= neg_s[QUO_W] ? COMP_W'(-q_sat) : COMP_W'(q_sat);
	end

	assign out_valid = out_v_q;
	assign unit      = unit_q;
endmodule

@@ sv/vector4_normalize.sv @@
// vector4_normalize top level: squares, root, four divider lanes, merge
// path from start to done: squares and sum registers, 17 root stages, the input,
//   quotient stage and output registers of each divider lane, the merge register
// throughput one beat per cycle; busy is always low and the receiver cannot stall
// asynchronous active-low reset clears valid flags and sets min_length to 4
module vector4_normalize import vn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [COMP_W-1:0] comp_x,
	input  logic signed [COMP_W-1:0] comp_y,
	input  logic signed [COMP_W-1:0] comp_z,
	input  logic signed [COMP_W-1:0] comp_w,
	input  logic                     cfg_we,
	input  logic [MAG_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic signed [COMP_W-1:0] unit_x,
	output logic signed [COMP_W-1:0] unit_y,
	output logic signed [COMP_W-1:0] unit_z,
	output logic signed [COMP_W-1:0] unit_w,
	output logic [MAG_W-1:0]         magnitude,
	output logic                     too_short
);
`include "vector4_normalize_defines.svh"

	// every stage advances each cycle, so nothing ever holds the sender off
	assign busy = 1'b0;

	// threshold register
	logic [MAG_W-1:0] min_length_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LEN_RST;
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	// stage 1: one squarer per lane
	comp4_t            vin;
	logic              v_s1;
	logic [31:0]       sq_s1 [LANES];
	comp4_t            vec_s1;
	assign vin = {comp_w, comp_z, comp_y, comp_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_sq
		always_ff @(posedge clk) begin
			sq_s1[i] <= 32'($signed(vin[i]) * $signed(vin[i]));
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vin;
	end

	// stage 2: sum of the four squares, unsigned 33-bit integer, up to 2^32
	logic             v_s2;
	logic [SUM_W-1:0] sum_s2;
	comp4_t           vec_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		sum_s2 <= ({1'b0, sq_s1[0]} + {1'b0, sq_s1[1]})
			+ ({1'b0, sq_s1[2]} + {1'b0, sq_s1[3]});
		vec_s2 <= vec_s1;
	end

	// length, floor of the square root
	logic             rt_valid;
	logic [MAG_W-1:0] rt_mag;
	comp4_t           rt_vec;
	vn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.radicand ({1'b0, sum_s2}),
		.vec_in   (vec_s2),
		.out_valid(rt_valid),
		.root     (rt_mag),
		.vec_out  (rt_vec)
	);

	// short-vector test; a zero length is always short
	logic rt_short;
	assign rt_short = (rt_mag <= min_length_q) || (rt_mag == '0);

	// four divider lanes side by side
	logic              ln_valid [LANES];
	logic [COMP_W-1:0] ln_unit  [LANES];
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		vn_div_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (rt_valid),
			.comp     ($signed(rt_vec[i])),
			.len      (rt_mag),
			.out_valid(ln_valid[i]),
			.unit     (ln_unit[i])
		);
	end

	// length and short flag ride alongside the lanes
	logic [MAG_W-1:0] mag_d   [0:LANE_LAT-1];
	logic             short_d [0:LANE_LAT-1];
	always_ff @(posedge clk) begin
		mag_d[0]   <= rt_mag;
		short_d[0] <= rt_short;
		for (int j = 1; j < LANE_LAT; j++) begin
			mag_d[j]   <= mag_d[j-1];
			short_d[j] <= short_d[j-1];
		end
	end

	// merge: zero the components of a short vector, register the beat
	logic                     done_q;
	logic [COMP_W-1:0]        unit_q [LANES];
	logic [MAG_W-1:0]         mag_q;
	logic                     short_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ln_valid[0];
		end
	end
	always_ff @(posedge clk) begin
		for (int j = 0; j < LANES; j++) begin
			unit_q[j] <= short_d[LANE_LAT-1] ? '0 : ln_unit[j];
		end
		mag_q   <= mag_d[LANE_LAT-1];
		short_q <= short_d[LANE_LAT-1];
	end

	assign done      = done_q;
	assign unit_x    = $signed(unit_q[0]);
	assign unit_y    = $signed(unit_q[1]);
	assign unit_z    = $signed(unit_q[2]);
	assign unit_w    = $signed(unit_q[3]);
	assign magnitude = mag_q;
	assign too_short = short_q;

	// a short beat carries a zero vector
	`VN_ASSERT_IMP(a_short_zero, done && too_short,
		unit_x == '0 && unit_y == '0 && unit_z == '0 && unit_w == '0)
	// a usable beat never has a zero length
	`VN_ASSERT_IMP(a_len_nonzero, done && !too_short, magnitude != '0)
	// lanes stay in lock step with each other
	`VN_ASSERT_IMP(a_lane_sync, ln_valid[0],
		ln_valid[1] && ln_valid[2] && ln_valid[3])
	// saturation keeps the most negative code out
	`VN_ASSERT_NXT(a_no_minneg, ln_valid[0],
		unit_x != 16'sh8000 && unit_y != 16'sh8000
		&& unit_z != 16'sh8000 && unit_w != 16'sh8000)
endmodule
